// File: design/lli_pkg.sv
// Shared constants and types for the line-line intersection core.
`timescale 1ns / 1ps

package lli_pkg;

  // Default coordinate and fraction widths
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Result coordinate width (signed fixed point)
  localparam int OUT_BITS = 48;

  // Entries in the queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // Per-transaction control bits handed from the front end to the divider
  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

// File: design/lli_front.sv
// Front end: accepts line pairs, forms cross products and classifies them.
`timescale 1ns / 1ps

module lli_front #(
  parameter int COORD_BITS = lli_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lli_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_BITS-1:0]   in_a_x1,
  input  logic signed [COORD_BITS-1:0]   in_a_y1,
  input  logic signed [COORD_BITS-1:0]   in_a_x2,
  input  logic signed [COORD_BITS-1:0]   in_a_y2,
  input  logic signed [COORD_BITS-1:0]   in_b_x1,
  input  logic signed [COORD_BITS-1:0]   in_b_y1,
  input  logic signed [COORD_BITS-1:0]   in_b_x2,
  input  logic signed [COORD_BITS-1:0]   in_b_y2,
  input  logic                           q_full,
  output logic                           q_push,
  output lli_pkg::ctl_t                  q_ctl,
  output logic [2*COORD_BITS+2:0]        q_den_mag,
  output logic [3*COORD_BITS+2:0]        q_num_x_mag,
  output logic [3*COORD_BITS+2:0]        q_num_y_mag
);

  localparam int D_W   = COORD_BITS + 1;
  localparam int CA_W  = 2 * COORD_BITS + 1;
  localparam int DEN_W = 2 * D_W + 1;
  localparam int N_W   = 3 * COORD_BITS + 3;

  logic                    en;
  logic                    s1_v_r, s2_v_r;
  logic signed [D_W-1:0]   dxa_r, dya_r, dxb_r, dyb_r;
  logic signed [CA_W-1:0]  ca_r, cb_r;
  logic signed [DEN_W-1:0] den_r;
  logic signed [N_W-1:0]   nx_r, ny_r;

  logic signed [D_W-1:0]   dxa_nxt, dya_nxt, dxb_nxt, dyb_nxt;
  logic signed [CA_W-1:0]  ca_nxt, cb_nxt;
  logic signed [DEN_W-1:0] den_nxt;
  logic signed [N_W-1:0]   nx_nxt, ny_nxt;
  logic                    den_neg;

  // Pipeline advances unless the last stage is stuck behind a full queue
  assign en       = !s2_v_r || !q_full;
  assign in_ready = en;
  assign q_push   = s2_v_r && !q_full;

  // Stage 1: direction vectors and line constants
  assign dxa_nxt = D_W'(in_a_x1) - D_W'(in_a_x2);
  assign dya_nxt = D_W'(in_a_y1) - D_W'(in_a_y2);
  assign dxb_nxt = D_W'(in_b_x1) - D_W'(in_b_x2);
  assign dyb_nxt = D_W'(in_b_y1) - D_W'(in_b_y2);
  assign ca_nxt  = CA_W'(in_a_x1) * CA_W'(in_a_y2) - CA_W'(in_a_y1) * CA_W'(in_a_x2);
  assign cb_nxt  = CA_W'(in_b_x1) * CA_W'(in_b_y2) - CA_W'(in_b_y1) * CA_W'(in_b_x2);

  // Stage 2: determinant and numerators
  assign den_nxt = DEN_W'(dxa_r) * DEN_W'(dyb_r) - DEN_W'(dya_r) * DEN_W'(dxb_r);
  assign nx_nxt  = N_W'(ca_r) * N_W'(dxb_r) - N_W'(dxa_r) * N_W'(cb_r);
  assign ny_nxt  = N_W'(ca_r) * N_W'(dyb_r) - N_W'(dya_r) * N_W'(cb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxa_r <= dxa_nxt;
      dya_r <= dya_nxt;
      dxb_r <= dxb_nxt;
      dyb_r <= dyb_nxt;
      ca_r  <= ca_nxt;
      cb_r  <= cb_nxt;
      den_r <= den_nxt;
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
    end
  end

  // Classification: parallel test, result signs and magnitudes
  assign den_neg         = den_r[DEN_W-1];
  assign q_ctl.hit       = (den_r != '0);
  assign q_ctl.neg_x     = nx_r[N_W-1] ^ den_neg;
  assign q_ctl.neg_y     = ny_r[N_W-1] ^ den_neg;
  assign q_den_mag       = den_neg ? DEN_W'(-den_r) : DEN_W'(den_r);
  assign q_num_x_mag     = nx_r[N_W-1] ? N_W'(-nx_r) : N_W'(nx_r);
  assign q_num_y_mag     = ny_r[N_W-1] ? N_W'(-ny_r) : N_W'(ny_r);

endmodule

// File: design/lli_queue.sv
// Small register queue between the front end and the divider.
`timescale 1ns / 1ps

module lli_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = lli_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue read while empty");
`endif

endmodule

// File: design/lli_divider.sv
// Back end: pipelined restoring divider for both coordinates, saturation, output.
`timescale 1ns / 1ps

module lli_divider #(
  parameter int COORD_BITS = lli_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lli_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  lli_pkg::ctl_t                       q_ctl,
  input  logic [2*COORD_BITS+2:0]             q_den_mag,
  input  logic [3*COORD_BITS+2:0]             q_num_x_mag,
  input  logic [3*COORD_BITS+2:0]             q_num_y_mag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic signed [lli_pkg::OUT_BITS-1:0] out_cross_x,
  output logic signed [lli_pkg::OUT_BITS-1:0] out_cross_y,
  output logic                                out_overflow
);

  localparam int OW    = lli_pkg::OUT_BITS;
  localparam int DEN_W = 2 * COORD_BITS + 3;
  localparam int N_W   = 3 * COORD_BITS + 3;
  localparam int NM    = N_W + FRAC_BITS;
  localparam int QW    = (NM > OW) ? NM : OW;

  logic                en;
  logic                v_r   [NM+1];
  lli_pkg::ctl_t       ctl_r [NM+1];
  logic [DEN_W-1:0]    ad_r  [NM+1];
  logic [DEN_W-1:0]    rx_r  [NM+1];
  logic [DEN_W-1:0]    ry_r  [NM+1];
  logic [NM-1:0]       qx_r  [NM+1];
  logic [NM-1:0]       qy_r  [NM+1];

  logic [DEN_W:0]      tx     [NM];
  logic [DEN_W:0]      ty     [NM];
  logic                gex    [NM];
  logic                gey    [NM];
  logic [DEN_W-1:0]    rx_nxt [NM];
  logic [DEN_W-1:0]    ry_nxt [NM];

  logic                out_valid_r, out_hit_r, out_ovf_r;
  logic [OW-1:0]       out_x_r, out_y_r;

  // Whole back end moves when the output register is free or being drained
  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && !q_empty;

  // One quotient bit per stage; dividend shifts out as quotient shifts in
  always_comb begin
    for (int k = 0; k < NM; k++) begin
      tx[k]     = {rx_r[k], qx_r[k][NM-1]};
      ty[k]     = {ry_r[k], qy_r[k][NM-1]};
      gex[k]    = (tx[k] >= {1'b0, ad_r[k]});
      gey[k]    = (ty[k] >= {1'b0, ad_r[k]});
      rx_nxt[k] = gex[k] ? DEN_W'(tx[k] - {1'b0, ad_r[k]}) : DEN_W'(tx[k]);
      ry_nxt[k] = gey[k] ? DEN_W'(ty[k] - {1'b0, ad_r[k]}) : DEN_W'(ty[k]);
    end
  end

  // Stage valid bits; stage 0 loads whenever a transaction is popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NM; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= q_pop;
      for (int k = 0; k < NM; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  // Stage 0 loads the dividend (numerator scaled by the fraction bits)
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= q_ctl;
      ad_r[0]  <= q_den_mag;
      rx_r[0]  <= '0;
      ry_r[0]  <= '0;
      qx_r[0]  <= NM'(q_num_x_mag) << FRAC_BITS;
      qy_r[0]  <= NM'(q_num_y_mag) << FRAC_BITS;
      for (int k = 0; k < NM; k++) begin
        ctl_r[k+1] <= ctl_r[k];
        ad_r[k+1]  <= ad_r[k];
        rx_r[k+1]  <= rx_nxt[k];
        ry_r[k+1]  <= ry_nxt[k];
        qx_r[k+1]  <= {qx_r[k][NM-2:0], gex[k]};
        qy_r[k+1]  <= {qy_r[k][NM-2:0], gey[k]};
      end
    end
  end

  // Saturate to the output range and apply sign
  logic [QW-1:0] qxe, qye, lim_x, lim_y, qxs, qys;
  logic          sat_x, sat_y;
  logic [OW-1:0] res_x, res_y;
  lli_pkg::ctl_t ctl_last;

  assign ctl_last = ctl_r[NM];
  assign qxe      = QW'(qx_r[NM]);
  assign qye      = QW'(qy_r[NM]);
  assign lim_x    = QW'({1'b0, {(OW-1){1'b1}}}) + QW'(ctl_last.neg_x);
  assign lim_y    = QW'({1'b0, {(OW-1){1'b1}}}) + QW'(ctl_last.neg_y);
  assign sat_x    = (qxe > lim_x);
  assign sat_y    = (qye > lim_y);
  assign qxs      = sat_x ? lim_x : qxe;
  assign qys      = sat_y ? lim_y : qye;
  assign res_x    = ctl_last.neg_x ? OW'(-qxs[OW-1:0]) : qxs[OW-1:0];
  assign res_y    = ctl_last.neg_y ? OW'(-qys[OW-1:0]) : qys[OW-1:0];

  // Output register; parallel pairs report all zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NM];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= ctl_last.hit;
      out_x_r   <= ctl_last.hit ? res_x : '0;
      out_y_r   <= ctl_last.hit ? res_y : '0;
      out_ovf_r <= ctl_last.hit && (sat_x || sat_y);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_cross_x  = out_x_r;
  assign out_cross_y  = out_y_r;
  assign out_overflow = out_ovf_r;

`ifndef SYNTHESIS
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_x_r == '0 && out_y_r == '0 && !out_ovf_r))
    else $error("parallel transaction with nonzero result");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_x_r) && $stable(out_y_r)))
    else $error("result changed while stalled");
`endif

endmodule

// File: design/line_line_intersection_core.sv
// Top level of the line-line intersection core.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_valid / in_ready   | a_x1 a_y1 a_x2 a_y2 b_x1 b_y1 b_x2 b_y2
//  out_    | out | out_valid / out_ready | hit cross_x cross_y overflow
//
// One transaction per cycle sustained while the queue has room and results are taken.
// A result passes the front-end stages, the queue, the 67-stage divider at the
// defaults (one-bit-per-stage restoring) and the output register. Reset is synchronous,
// active low, and clears only valid and queue state. The front end stalls only when the
// queue is full; the divider and output register stall together when a result is not taken.
`timescale 1ns / 1ps

module line_line_intersection_core #(
  parameter int COORD_BITS = lli_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lli_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        in_a_x1,
  input  logic signed [COORD_BITS-1:0]        in_a_y1,
  input  logic signed [COORD_BITS-1:0]        in_a_x2,
  input  logic signed [COORD_BITS-1:0]        in_a_y2,
  input  logic signed [COORD_BITS-1:0]        in_b_x1,
  input  logic signed [COORD_BITS-1:0]        in_b_y1,
  input  logic signed [COORD_BITS-1:0]        in_b_x2,
  input  logic signed [COORD_BITS-1:0]        in_b_y2,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic signed [lli_pkg::OUT_BITS-1:0] out_cross_x,
  output logic signed [lli_pkg::OUT_BITS-1:0] out_cross_y,
  output logic                                out_overflow
);

  localparam int DEN_W  = 2 * COORD_BITS + 3;
  localparam int N_W    = 3 * COORD_BITS + 3;
  localparam int CTL_W  = $bits(lli_pkg::ctl_t);
  localparam int DATA_W = CTL_W + DEN_W + 2 * N_W;

  logic              q_full, q_empty, q_push, q_pop;
  lli_pkg::ctl_t     f_ctl, b_ctl;
  logic [DEN_W-1:0]  f_den, b_den;
  logic [N_W-1:0]    f_nx, f_ny, b_nx, b_ny;
  logic [DATA_W-1:0] q_wr, q_rd;

  lli_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_a_x1     (in_a_x1),
    .in_a_y1     (in_a_y1),
    .in_a_x2     (in_a_x2),
    .in_a_y2     (in_a_y2),
    .in_b_x1     (in_b_x1),
    .in_b_y1     (in_b_y1),
    .in_b_x2     (in_b_x2),
    .in_b_y2     (in_b_y2),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ctl       (f_ctl),
    .q_den_mag   (f_den),
    .q_num_x_mag (f_nx),
    .q_num_y_mag (f_ny)
  );

  // Queue entry layout: control, divisor, two dividends
  assign q_wr = {f_ctl, f_den, f_nx, f_ny};
  assign {b_ctl, b_den, b_nx, b_ny} = q_rd;

  lli_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (lli_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  lli_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_ctl        (b_ctl),
    .q_den_mag    (b_den),
    .q_num_x_mag  (b_nx),
    .q_num_y_mag  (b_ny),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit),
    .out_cross_x  (out_cross_x),
    .out_cross_y  (out_cross_y),
    .out_overflow (out_overflow)
  );

`ifndef SYNTHESIS
  a_ovf_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> out_hit)
    else $error("overflow flagged on a parallel pair");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the line-line intersection core.
`timescale 1ns / 1ps

module tb_top;

  localparam int CB = lli_pkg::COORD_BITS_DEF;
  localparam int FB = lli_pkg::FRAC_BITS_DEF;
  localparam int LAT = 3 * CB + FB + 7;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [lli_pkg::OUT_BITS-1:0] fix_t;

  typedef struct {
    logic hit;
    fix_t x;
    fix_t y;
    logic ovf;
  } isect_t;

  // one directed row: two lines, plus an optional typed-in answer
  typedef struct {
    coord_t pt[8];
    bit     typed;
    isect_t ans;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t pin[8];
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  fix_t out_cross_x;
  fix_t out_cross_y;
  logic out_overflow;

  isect_t pending_isect[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #1 clk = ~clk;

  line_line_intersection_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_x1(pin[0]), .in_a_y1(pin[1]), .in_a_x2(pin[2]), .in_a_y2(pin[3]),
    .in_b_x1(pin[4]), .in_b_y1(pin[5]), .in_b_x2(pin[6]), .in_b_y2(pin[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_cross_x(out_cross_x), .out_cross_y(out_cross_y),
    .out_overflow(out_overflow)
  );

  // (num << FB) / den, truncated toward zero, clamped to the output range
  function automatic fix_t fixed_quot(input longint num, input longint den, inout logic ovf);
    logic signed [127:0] n;
    logic signed [127:0] d;
    logic signed [127:0] q;
    logic signed [127:0] hi_lim;
    logic signed [127:0] lo_lim;
    n = num;
    n = n <<< FB;
    d = den;
    q = n / d;
    hi_lim = (128'sd1 <<< (lli_pkg::OUT_BITS - 1)) - 1;
    lo_lim = -(128'sd1 <<< (lli_pkg::OUT_BITS - 1));
    if (q > hi_lim) begin
      q = hi_lim;
      ovf = 1'b1;
    end else if (q < lo_lim) begin
      q = lo_lim;
      ovf = 1'b1;
    end
    return q[lli_pkg::OUT_BITS-1:0];
  endfunction

  // exact intersection of line (p0,p1)-(p2,p3) with line (p4,p5)-(p6,p7)
  function automatic isect_t calc_isect(input coord_t p[8]);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint dxa, dya, dxb, dyb, den, ca, cb;
    isect_t r;
    x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3];
    x3 = p[4]; y3 = p[5]; x4 = p[6]; y4 = p[7];
    dxa = x1 - x2; dya = y1 - y2;
    dxb = x3 - x4; dyb = y3 - y4;
    den = dxa * dyb - dya * dxb;
    r = '{1'b0, '0, '0, 1'b0};
    if (den == 0) return r;
    ca = x1 * y2 - y1 * x2;
    cb = x3 * y4 - y3 * x4;
    r.hit = 1'b1;
    r.x = fixed_quot(ca * dxb - dxa * cb, den, r.ovf);
    r.y = fixed_quot(ca * dyb - dya * cb, den, r.ovf);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    isect_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_isect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0b x=%0d y=%0d ovf=%0b",
                   out_hit, out_cross_x, out_cross_y, out_overflow);
      end else begin
        e = pending_isect.pop_front();
        if (out_hit !== e.hit || out_cross_x !== e.x || out_cross_y !== e.y ||
            out_overflow !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b x=%0d y=%0d ovf=%0b, got hit=%0b x=%0d y=%0d ovf=%0b",
                     e.hit, e.x, e.y, e.ovf, out_hit, out_cross_x, out_cross_y,
                     out_overflow);
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // drive one transaction and record its expected result once accepted
  task automatic send_lines(input coord_t p[8], input bit typed, input isect_t ans);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    pin = p;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_isect = {pending_isect, (typed ? ans : calc_isect(p))};
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic coord_t rnd_coord(input int span);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  // random pair of lines: generic, nearly parallel, parallel or degenerate
  function automatic void rnd_lines(output coord_t p[8]);
    int kind;
    int dx, dy;
    kind = $urandom_range(9);
    foreach (p[i]) p[i] = coord_t'($urandom);
    if (kind == 6) begin
      // parallel or coincident, kept small so the offset cannot wrap
      foreach (p[i]) p[i] = rnd_coord(4000);
      dx = p[2] - p[0]; dy = p[3] - p[1];
      if ($urandom_range(1)) begin
        p[4] = p[0]; p[5] = p[1];
      end
      p[6] = coord_t'(p[4] + dx); p[7] = coord_t'(p[5] + dy);
    end else if (kind == 7) begin
      // nearly parallel: directions differ by one unit
      foreach (p[i]) p[i] = rnd_coord(4000);
      dx = p[2] - p[0]; dy = p[3] - p[1];
      p[6] = coord_t'(p[4] + dx + 1); p[7] = coord_t'(p[5] + dy);
    end else if (kind == 8) begin
      // degenerate line with coincident points
      if ($urandom_range(1)) begin
        p[2] = p[0]; p[3] = p[1];
      end else begin
        p[6] = p[4]; p[7] = p[5];
      end
    end else if (kind == 9) begin
      foreach (p[i]) p[i] = rnd_coord(8);
    end
  endfunction

  localparam coord_t MX = coord_t'(32767);
  localparam coord_t MN = coord_t'(-32768);
  localparam isect_t NO_HIT = '{1'b0, '0, '0, 1'b0};
  localparam fix_t ONE = fix_t'(1 << FB);

  row_t directed[] = '{
    // each line's two points equal: both lines degenerate
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, NO_HIT},
    '{'{MX, MX, MX, MX, MN, MN, MN, MN}, 1, NO_HIT},
    // two vertical lines
    '{'{5, MN, 5, MX, -7, MN, -7, MX}, 1, NO_HIT},
    // coincident lines
    '{'{MN, MN, MX, MX, 0, 0, 1, 1}, 1, NO_HIT},
    // parallel at the extremes
    '{'{MN, 0, MX, 0, MN, 1, MX, 1}, 1, NO_HIT},
    // simple crossing at (1,1)
    '{'{0, 0, 2, 2, 0, 2, 2, 0}, 1, '{1'b1, ONE, ONE, 1'b0}},
    // crossing at the origin
    '{'{-1, 0, 1, 0, 0, -1, 0, 1}, 1, '{1'b1, '0, '0, 1'b0}},
    // fractional and negative results
    '{'{0, 0, 3, 1, 0, 1, 3, 0}, 0, NO_HIT},
    '{'{0, 0, -3, -1, 0, -1, -3, 0}, 0, NO_HIT},
    // long lines spanning the full range, some nearly parallel with far crossings
    '{'{MN, MN, MX, MX, MN, MX, MX, MN}, 0, NO_HIT},
    '{'{MN, MN, MX, MX, MN, -32767, MX, MX}, 0, NO_HIT},
    '{'{MN, MX, MX, MN, MN, 32766, MX, MN}, 0, NO_HIT},
    '{'{MX, MX, MN, MN, MX, MN, MN, MX}, 0, NO_HIT},
    '{'{MN, 0, MX, 1, MN, 1, MX, 3}, 0, NO_HIT},
    '{'{MX, 0, MN, -1, MX, 1, MN, -1}, 0, NO_HIT},
    '{'{MN, MN, MN, MX, MX, MN, MN, MX}, 0, NO_HIT}
  };

  initial begin
    coord_t p[8];
    isect_t dummy;
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 47, 0, 25};
    stall_tab = '{0, 0, 47, 25};
    foreach (pin[i]) pin[i] = '0;
    dummy = NO_HIT;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_lines(directed[i].pt, directed[i].typed, directed[i].ans);

    // random part across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      repeat (150) begin
        rnd_lines(p);
        send_lines(p, 0, dummy);
      end
    end
    recv_stall_pct = 0;

    while (pending_isect.size() != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // hang guard
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
